FILE: rtl/cws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Capture window sequencer package
// Shared widths, register indexes, limits and the structures that pass
// between the sequencer modules.
// ----------------------------------------------------------------------------
package cws_pkg;

    localparam int TIME_W  = 48;
    localparam int SWEEP_W = 48;
    localparam int PKT_W   = 32;
    localparam int LIM_W   = 20;
    localparam int CFG_IDX_W = 3;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 8;

    localparam logic [LIM_W-1:0] LIMIT_MAX = 20'd1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_DURATION  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_SWEEPS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_PACKETS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_ENABLE = 3'd4;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ARM  = 1'b1;

    typedef struct packed {
        logic [LIM_W-1:0] start_delay_ms;
        logic [LIM_W-1:0] run_duration_ms;
        logic [LIM_W-1:0] stop_after_sweeps;
        logic [LIM_W-1:0] stop_after_packets;
        logic             record_enable;
    } t_cfg;

    typedef struct packed {
        logic               op;
        logic [TIME_W-1:0]  now_time;
        logic [SWEEP_W-1:0] sweeps_done;
        logic [PKT_W-1:0]   packet_seq;
        logic               replay_on;
        logic               scan_on;
        logic               recording_on;
        logic               recording_fault;
        logic               record_start_fails;
    } t_item;

    typedef struct packed {
        logic record_stop_req;
        logic scan_stop_req;
        logic record_start_req;
        logic scan_start_req;
        logic start_error;
        logic running;
        logic armed;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/cws_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the run settings; limit registers saturate on write.
// ----------------------------------------------------------------------------
module cws_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [cws_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cws_pkg::LIM_W-1:0]        i_cfg_wdata,
    output cws_pkg::t_cfg                         o_cfg
);

    cws_pkg::t_cfg           r_cfg;
    logic [cws_pkg::LIM_W-1:0] n_limit;

    always_comb begin
        n_limit = (i_cfg_wdata > cws_pkg::LIMIT_MAX) ? cws_pkg::LIMIT_MAX : i_cfg_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cws_pkg::CFG_START_DELAY:   r_cfg.start_delay_ms     <= n_limit;
                cws_pkg::CFG_RUN_DURATION:  r_cfg.run_duration_ms    <= n_limit;
                cws_pkg::CFG_STOP_SWEEPS:   r_cfg.stop_after_sweeps  <= n_limit;
                cws_pkg::CFG_STOP_PACKETS:  r_cfg.stop_after_packets <= n_limit;
                cws_pkg::CFG_RECORD_ENABLE: r_cfg.record_enable      <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

FILE: rtl/cws_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequencer core
// Run state and the single-pass arm, start and stop decisions for one request.
// ----------------------------------------------------------------------------
module cws_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_advance,
    input  wire cws_pkg::t_cfg    i_cfg,
    input  wire cws_pkg::t_item   i_item,
    output cws_pkg::t_result o_result
);

    logic                         r_armed, n_armed;
    logic                         r_running, n_running;
    logic                         r_error, n_error;
    logic [cws_pkg::TIME_W-1:0]   r_start_time, n_start_time;
    logic [cws_pkg::TIME_W-1:0]   r_stop_time, n_stop_time;
    logic [cws_pkg::SWEEP_W-1:0]  r_sweeps_at_start, n_sweeps_at_start;
    logic [cws_pkg::PKT_W-1:0]    r_packets_at_start, n_packets_at_start;

    logic [cws_pkg::TIME_W-1:0]   arm_time;
    logic [cws_pkg::TIME_W-1:0]   end_time;
    logic [cws_pkg::SWEEP_W-1:0]  sweep_delta;
    logic [cws_pkg::PKT_W-1:0]    pkt_delta;
    logic                         stop_hit;
    logic                         disarm;
    logic                         rec_fail;

    assign arm_time = i_item.now_time
        + {{(cws_pkg::TIME_W-cws_pkg::LIM_W){1'b0}}, i_cfg.start_delay_ms};
    assign end_time = i_item.now_time
        + {{(cws_pkg::TIME_W-cws_pkg::LIM_W){1'b0}}, i_cfg.run_duration_ms};
    assign sweep_delta = i_item.sweeps_done - r_sweeps_at_start;
    assign pkt_delta   = i_item.packet_seq - r_packets_at_start;

    always_comb begin
        stop_hit = 1'b0;
        if ((i_cfg.run_duration_ms != '0) && (r_stop_time != '0)
            && (i_item.now_time >= r_stop_time)) begin
            stop_hit = 1'b1;
        end
        if ((i_cfg.stop_after_sweeps != '0) && (i_item.sweeps_done >= r_sweeps_at_start)
            && (sweep_delta >= {{(cws_pkg::SWEEP_W-cws_pkg::LIM_W){1'b0}},
                                i_cfg.stop_after_sweeps})) begin
            stop_hit = 1'b1;
        end
        if ((i_cfg.stop_after_packets != '0) && (i_item.packet_seq >= r_packets_at_start)
            && (pkt_delta >= {{(cws_pkg::PKT_W-cws_pkg::LIM_W){1'b0}},
                              i_cfg.stop_after_packets})) begin
            stop_hit = 1'b1;
        end
        if (i_item.recording_fault) begin
            stop_hit = 1'b1;
        end
    end

    always_comb begin
        n_armed            = r_armed;
        n_running          = r_running;
        n_error            = r_error;
        n_start_time       = r_start_time;
        n_stop_time        = r_stop_time;
        n_sweeps_at_start  = r_sweeps_at_start;
        n_packets_at_start = r_packets_at_start;
        o_result           = '0;
        disarm             = 1'b0;
        rec_fail           = 1'b0;

        if (i_item.op == cws_pkg::OP_ARM) begin
            if (r_armed) begin
                disarm = 1'b1;
            end else begin
                n_armed      = 1'b1;
                n_running    = 1'b0;
                n_error      = 1'b0;
                n_start_time = arm_time;
                n_stop_time  = '0;
            end
        end else if (!i_item.replay_on && r_armed) begin
            if (!r_running) begin
                if (i_item.now_time >= r_start_time) begin
                    n_running          = 1'b1;
                    n_sweeps_at_start  = i_item.sweeps_done;
                    n_packets_at_start = i_item.packet_seq;
                    n_error            = 1'b0;
                    o_result.scan_start_req = !i_item.scan_on;
                    if (i_cfg.record_enable && !i_item.recording_on) begin
                        o_result.record_start_req = 1'b1;
                        rec_fail = i_item.record_start_fails;
                    end
                    if (rec_fail) begin
                        n_error   = 1'b1;
                        n_armed   = 1'b0;
                        n_running = 1'b0;
                    end else begin
                        n_stop_time = (i_cfg.run_duration_ms != '0) ? end_time : '0;
                    end
                end
            end else if (stop_hit) begin
                disarm = 1'b1;
            end
        end

        if (disarm) begin
            n_armed            = 1'b0;
            n_running          = 1'b0;
            n_error            = 1'b0;
            n_start_time       = '0;
            n_stop_time        = '0;
            n_sweeps_at_start  = '0;
            n_packets_at_start = '0;
            o_result.record_stop_req = r_running && i_item.recording_on;
            o_result.scan_stop_req   = r_running && i_item.scan_on;
        end

        o_result.armed       = n_armed;
        o_result.running     = n_running;
        o_result.start_error = n_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed            <= 1'b0;
            r_running          <= 1'b0;
            r_error            <= 1'b0;
            r_start_time       <= '0;
            r_stop_time        <= '0;
            r_sweeps_at_start  <= '0;
            r_packets_at_start <= '0;
        end else if (i_advance) begin
            r_armed            <= n_armed;
            r_running          <= n_running;
            r_error            <= n_error;
            r_start_time       <= n_start_time;
            r_stop_time        <= n_stop_time;
            r_sweeps_at_start  <= n_sweeps_at_start;
            r_packets_at_start <= n_packets_at_start;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/capture_window_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Capture window sequencer
// Arms, starts and stops one capture run from tick and arm-toggle requests.
// ----------------------------------------------------------------------------
// The block takes one request per clock when not stalled and returns exactly
// one result per request, held first in the input register and then in the
// result register, with the decision logic between them. The result register
// lets a new request enter while the previous result waits to be taken.
// Configuration writes must be made while no request is in flight.
module capture_window_sequencer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output      logic                               s_axis_tready,
    // now_time[47:0], sweeps_done[95:48], packet_seq[127:96], replay_on[128],
    // scan_on[129], recording_on[130], recording_fault[131],
    // record_start_fails[132], zero fill[135:133]
    input  wire logic [cws_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // op[0]
    input  wire logic                               s_axis_tuser,
    output      logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // armed[0], running[1], start_error[2], scan_start_req[3],
    // record_start_req[4], scan_stop_req[5], record_stop_req[6], zero fill[7]
    output      logic [cws_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  wire logic                               i_cfg_we,
    input  wire logic [cws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [cws_pkg::LIM_W-1:0]          i_cfg_wdata
);

    logic                r_in_valid;
    cws_pkg::t_item      r_in_item;
    cws_pkg::t_item      n_in_item;
    logic                r_out_valid;
    cws_pkg::t_result    r_out_result;
    cws_pkg::t_result    core_result;
    cws_pkg::t_cfg       cfg;
    logic                advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        n_in_item.op                 = s_axis_tuser;
        n_in_item.now_time           = s_axis_tdata[47:0];
        n_in_item.sweeps_done        = s_axis_tdata[95:48];
        n_in_item.packet_seq         = s_axis_tdata[127:96];
        n_in_item.replay_on          = s_axis_tdata[128];
        n_in_item.scan_on            = s_axis_tdata[129];
        n_in_item.recording_on       = s_axis_tdata[130];
        n_in_item.recording_fault    = s_axis_tdata[131];
        n_in_item.record_start_fails = s_axis_tdata[132];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= n_in_item;
        end
    end

    cws_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    cws_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_cfg     (cfg),
        .i_item    (r_in_item),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_result <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_result};

endmodule
`default_nettype wire

FILE: rtl/cws_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequencer port checker
// Watches the result stream for inconsistent run state and request pulses.
// ----------------------------------------------------------------------------
module cws_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [cws_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("Result changed or vanished while stalled.");

    a_running_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
        else $error("Running reported without being armed.");

    a_error_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> (!m_axis_tdata[0] && !m_axis_tdata[1]))
        else $error("Start error reported while still armed or running.");

    a_start_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !((m_axis_tdata[3] || m_axis_tdata[4])
                            && (m_axis_tdata[5] || m_axis_tdata[6])))
        else $error("Start and stop requests raised by the same request.");

endmodule

bind capture_window_sequencer cws_checker u_cws_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: verif/tb_capture_window_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture window sequencer testbench
// Drives arm and tick requests through the stream input while the result
// side stalls on its own pattern. Every request updates a local model of the
// arm, run and stop decisions, and each returned result is checked field by
// field against it. A short directed table covers time wrap, saturation and
// every stop cause; randomised capture sessions under changing settings follow.
// ----------------------------------------------------------------------------
module tb_capture_window_sequencer;
    import cws_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQUESTS = 400;
    localparam logic [TIME_W-1:0] T_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TOP = '1;

    typedef enum bit {ROW_CFG, ROW_REQ} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [LIM_W-1:0]      value;
        t_item                 req;
        bit                    typed;
        t_result               outcome;
    } plan_row_t;

    localparam t_result NO_CHECK = '0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [LIM_W-1:0]      i_cfg_wdata = '0;

    capture_window_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Local copy of the settings and of the sequencer state.
    logic [LIM_W-1:0]   delay_ticks = '0;
    logic [LIM_W-1:0]   duration_ticks = '0;
    logic [LIM_W-1:0]   sweep_limit = '0;
    logic [LIM_W-1:0]   packet_limit = '0;
    logic               record_on_start = 1'b0;
    logic               armed_now = 1'b0;
    logic               run_active = 1'b0;
    logic               start_err = 1'b0;
    logic [TIME_W-1:0]  start_at = '0;
    logic [TIME_W-1:0]  stop_at = '0;
    logic [SWEEP_W-1:0] sweep_base = '0;
    logic [PKT_W-1:0]   packet_base = '0;

    t_result pending_outcomes[$];
    plan_row_t plan[$];
    string field_name[7] = '{"armed", "running", "start_error", "scan_start_req",
                             "record_start_req", "scan_stop_req", "record_stop_req"};

    int fail_count = 0;
    int checked_count = 0;
    int sent_count = 0;
    int live_requests = 0;
    int runs_started = 0;
    int starts_failed = 0;
    int runs_stopped = 0;
    int settings_written = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int burst_left = 0;
    int ready_mode = 0;
    int ready_run = 0;
    t_result seen;
    t_result wanted;

    function automatic t_item req_item(bit op, logic [TIME_W-1:0] now,
                                       logic [SWEEP_W-1:0] sweeps, logic [PKT_W-1:0] pkt,
                                       bit replay, bit scan, bit rec, bit fault, bit fails);
        t_item it;
        it.op = op;
        it.now_time = now;
        it.sweeps_done = sweeps;
        it.packet_seq = pkt;
        it.replay_on = replay;
        it.scan_on = scan;
        it.recording_on = rec;
        it.recording_fault = fault;
        it.record_start_fails = fails;
        return it;
    endfunction

    function automatic t_result outcome(bit armed, bit running, bit err, bit scan_start,
                                        bit rec_start, bit scan_stop, bit rec_stop);
        t_result r;
        r.armed = armed;
        r.running = running;
        r.start_error = err;
        r.scan_start_req = scan_start;
        r.record_start_req = rec_start;
        r.scan_stop_req = scan_stop;
        r.record_stop_req = rec_stop;
        return r;
    endfunction

    function automatic logic [LIM_W-1:0] clamp_limit(logic [LIM_W-1:0] v);
        return (v > LIMIT_MAX) ? LIMIT_MAX : v;
    endfunction

    // Disarming clears everything; stop requests only follow an active run.
    function automatic void end_window(t_item it, inout t_result r);
        if (run_active) begin
            r.record_stop_req = it.recording_on;
            r.scan_stop_req = it.scan_on;
        end
        armed_now = 1'b0;
        run_active = 1'b0;
        start_err = 1'b0;
        start_at = '0;
        stop_at = '0;
        sweep_base = '0;
        packet_base = '0;
    endfunction

    function automatic t_result next_outcome(t_item it);
        t_result r;
        logic    halt;
        r = '0;
        if (it.op == OP_ARM) begin
            if (armed_now) begin
                end_window(it, r);
            end else begin
                armed_now = 1'b1;
                run_active = 1'b0;
                start_err = 1'b0;
                start_at = it.now_time + delay_ticks;
                stop_at = '0;
            end
        end else if (!it.replay_on && armed_now) begin
            if (!run_active) begin
                if (it.now_time >= start_at) begin
                    runs_started++;
                    run_active = 1'b1;
                    sweep_base = it.sweeps_done;
                    packet_base = it.packet_seq;
                    start_err = 1'b0;
                    r.scan_start_req = !it.scan_on;
                    if (record_on_start && !it.recording_on) begin
                        r.record_start_req = 1'b1;
                        if (it.record_start_fails) begin
                            starts_failed++;
                            start_err = 1'b1;
                            armed_now = 1'b0;
                            run_active = 1'b0;
                        end
                    end
                    if (run_active) begin
                        stop_at = (duration_ticks != 0) ? it.now_time + duration_ticks : '0;
                    end
                end
            end else begin
                halt = (duration_ticks != 0 && stop_at != 0 && it.now_time >= stop_at)
                    || (sweep_limit != 0 && it.sweeps_done >= sweep_base
                        && it.sweeps_done - sweep_base >= sweep_limit)
                    || (packet_limit != 0 && it.packet_seq >= packet_base
                        && PKT_W'(it.packet_seq - packet_base) >= packet_limit)
                    || it.recording_fault;
                if (halt) begin
                    runs_stopped++;
                    end_window(it, r);
                end
            end
        end
        r.armed = armed_now;
        r.running = run_active;
        r.start_error = start_err;
        return r;
    endfunction

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [LIM_W-1:0] value);
        drain_pipeline();
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        settings_written++;
        case (index)
            CFG_START_DELAY:   delay_ticks = clamp_limit(value);
            CFG_RUN_DURATION:  duration_ticks = clamp_limit(value);
            CFG_STOP_SWEEPS:   sweep_limit = clamp_limit(value);
            CFG_STOP_PACKETS:  packet_limit = clamp_limit(value);
            CFG_RECORD_ENABLE: record_on_start = value[0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(t_item it, bit typed, t_result typed_outcome);
        t_result predicted;
        if (gap_left > 0) s_axis_tvalid <= 1'b0;
        while (gap_left > 0) begin
            @(posedge i_clk);
            gap_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.op;
        s_axis_tdata <= {3'b000, it.record_start_fails, it.recording_fault, it.recording_on,
                         it.scan_on, it.replay_on, it.packet_seq, it.sweeps_done, it.now_time};
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
        if (!(it.op == OP_TICK && (it.replay_on || !armed_now))) live_requests++;
        predicted = next_outcome(it);
        pending_outcomes.push_back(typed ? typed_outcome : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
    endtask

    task automatic add_req(t_item it, bit typed, t_result r);
        plan_row_t row;
        row.kind = ROW_REQ;
        row.index = '0;
        row.value = '0;
        row.req = it;
        row.typed = typed;
        row.outcome = r;
        plan.push_back(row);
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] index, logic [LIM_W-1:0] value);
        plan_row_t row;
        row.kind = ROW_CFG;
        row.index = index;
        row.value = value;
        row.req = '0;
        row.typed = 1'b0;
        row.outcome = NO_CHECK;
        plan.push_back(row);
    endtask

    function automatic logic [LIM_W-1:0] pick_limit(int small_max);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LIMIT_MAX;
            2: return LIM_W'($urandom_range(1000001, 1048575));
            default: return LIM_W'($urandom_range(0, small_max));
        endcase
    endfunction

    task automatic random_settings();
        write_register(CFG_START_DELAY, pick_limit(20));
        write_register(CFG_RUN_DURATION, pick_limit(40));
        write_register(CFG_STOP_SWEEPS, pick_limit(8));
        write_register(CFG_STOP_PACKETS, pick_limit(12));
        write_register(CFG_RECORD_ENABLE, LIM_W'($urandom));
        if ($urandom_range(0, 2) == 0) begin
            write_register(CFG_INDEX_TOP - CFG_IDX_W'($urandom_range(0, 2)), LIM_W'($urandom));
        end
    endtask

    // One capture session: an arm request followed by ticks whose counters mostly
    // advance, with the odd toggle, replay, fault, jump and unrelated noise.
    task automatic random_session();
        logic [TIME_W-1:0]  t;
        logic [SWEEP_W-1:0] sw;
        logic [PKT_W-1:0]   pk;
        int                 n;
        t_item              it;
        t = ($urandom_range(0, 3) == 0) ? T_MAX - TIME_W'($urandom_range(0, 60))
                                        : {16'($urandom), 32'($urandom)};
        sw = {16'($urandom), 32'($urandom)};
        pk = ($urandom_range(0, 3) == 0) ? PKT_W'(-$urandom_range(1, 8)) : PKT_W'($urandom);
        send_request(req_item(OP_ARM, t, sw, pk, $urandom_range(0, 3) == 0, 1'($urandom),
                              1'($urandom), 1'b0, 1'b0), 1'b0, NO_CHECK);
        n = $urandom_range(3, 25);
        repeat (n) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    it = req_item(1'($urandom), {16'($urandom), 32'($urandom)},
                                  {16'($urandom), 32'($urandom)}, PKT_W'($urandom),
                                  1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                                  1'($urandom));
                end
                2: begin
                    it = req_item(OP_ARM, t, sw, pk, 1'($urandom), 1'($urandom),
                                  1'($urandom), 1'($urandom), 1'($urandom));
                end
                default: begin
                    if ($urandom_range(0, 9) == 0) t += TIME_W'($urandom_range(0, 1100000));
                    else t += TIME_W'($urandom_range(0, 4));
                    if ($urandom_range(0, 9) == 0) sw -= SWEEP_W'($urandom_range(1, 3));
                    else sw += SWEEP_W'($urandom_range(0, 2));
                    if ($urandom_range(0, 9) == 0) pk -= PKT_W'($urandom_range(1, 3));
                    else pk += PKT_W'($urandom_range(0, 3));
                    it = req_item(OP_TICK, t, sw, pk, $urandom_range(0, 7) == 0,
                                  1'($urandom), 1'($urandom), $urandom_range(0, 24) == 0,
                                  $urandom_range(0, 3) == 0);
                end
            endcase
            send_request(it, 1'b0, NO_CHECK);
        end
    endtask

    always @(posedge i_clk) begin
        if (ready_run == 0) begin
            ready_mode <= $urandom_range(0, 2);
            ready_run <= $urandom_range(4, 40);
        end else begin
            ready_run <= ready_run - 1;
        end
        case (ready_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom);
            default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = t_result'(m_axis_tdata[6:0]);
            if (pending_outcomes.size() == 0) begin
                $error("result 0x%02h arrived with no request outstanding", m_axis_tdata);
                fail_count++;
            end else begin
                wanted = pending_outcomes.pop_front();
                checked_count++;
                for (int b = 0; b < 7; b++) begin
                    if (seen[b] !== wanted[b]) begin
                        $error("%s: expected %0b, got %0b", field_name[b], wanted[b], seen[b]);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out with %0d results outstanding.", pending_outcomes.size());
            $display("tb_capture_window_sequencer NOT OK");
            $finish;
        end
    end

    initial begin
        int directed_sent;
        int sessions;

        // Reset settings: zero delay, no limits, no recording.
        add_req(req_item(OP_TICK, '0, '0, '0, 0, 0, 0, 0, 0), 1'b1, outcome(0, 0, 0, 0, 0, 0, 0));
        add_req(req_item(OP_ARM, T_MAX, T_MAX, '1, 1, 0, 0, 0, 0), 1'b1,
                outcome(1, 0, 0, 0, 0, 0, 0));
        add_req(req_item(OP_TICK, T_MAX, T_MAX, '1, 1, 0, 0, 0, 0), 1'b1,
                outcome(1, 0, 0, 0, 0, 0, 0));
        add_req(req_item(OP_TICK, T_MAX, T_MAX, '1, 0, 0, 0, 0, 0), 1'b1,
                outcome(1, 1, 0, 1, 0, 0, 0));
        add_req(req_item(OP_ARM, '0, '0, '0, 0, 1, 1, 0, 0), 1'b1, outcome(0, 0, 0, 0, 0, 1, 1));

        // Over-range writes saturate; the start time wraps past the top of time.
        add_cfg(CFG_START_DELAY, '1);
        add_cfg(CFG_RUN_DURATION, 20'd1000);
        add_cfg(CFG_STOP_SWEEPS, 20'd5);
        add_cfg(CFG_STOP_PACKETS, '1);
        add_cfg(CFG_RECORD_ENABLE, 20'd1);
        add_req(req_item(OP_ARM, T_MAX - 9, '0, '0, 0, 0, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, 48'd5, '0, '0, 0, 0, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, 48'd999990, '0, '0, 0, 0, 0, 0, 1), 1'b1,
                outcome(0, 0, 1, 1, 1, 0, 0));
        add_req(req_item(OP_ARM, '0, '0, '0, 0, 0, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, 48'd1000000, 48'd100, 32'hFFFF_FFF0, 0, 1, 0, 0, 0), 1'b0,
                NO_CHECK);
        add_req(req_item(OP_TICK, 48'd1000500, 48'd50, 32'h10, 0, 1, 1, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, 48'd1000600, 48'd105, 32'h10, 0, 1, 1, 0, 0), 1'b0, NO_CHECK);

        // Stop time wraps to zero, then packet, duration and fault stops.
        add_cfg(CFG_START_DELAY, '0);
        add_cfg(CFG_RUN_DURATION, LIMIT_MAX);
        add_cfg(CFG_STOP_SWEEPS, '0);
        add_cfg(CFG_STOP_PACKETS, 20'd3);
        add_cfg(CFG_RECORD_ENABLE, '0);
        add_req(req_item(OP_ARM, T_MAX - 999999, '0, 32'd100, 0, 0, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, T_MAX - 999999, '0, 32'd100, 0, 0, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, T_MAX, '0, 32'd102, 0, 1, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, '0, '0, 32'd103, 0, 1, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_ARM, '0, '0, '0, 0, 0, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, '0, '0, '0, 0, 0, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, 48'd1000000, '0, '0, 0, 1, 1, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_ARM, 48'd5, '0, '0, 0, 0, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, 48'd5, '0, '0, 0, 0, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, 48'd6, '0, '0, 0, 0, 1, 1, 0), 1'b0, NO_CHECK);

        // Zero duration never times out; a write to a spare index has no effect.
        add_cfg(CFG_RUN_DURATION, '0);
        add_cfg(CFG_INDEX_TOP, '1);
        add_req(req_item(OP_ARM, 48'd10, '0, '0, 0, 0, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, 48'd10, '0, '0, 0, 0, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_TICK, T_MAX, '0, '0, 0, 0, 0, 0, 0), 1'b0, NO_CHECK);
        add_req(req_item(OP_ARM, T_MAX, '0, '0, 0, 1, 1, 0, 0), 1'b1,
                outcome(0, 0, 0, 0, 0, 1, 1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                write_register(plan[k].index, plan[k].value);
            end else begin
                send_request(plan[k].req, plan[k].typed, plan[k].outcome);
            end
        end

        directed_sent = sent_count;
        sessions = 0;
        while (sent_count - directed_sent < RANDOM_REQUESTS) begin
            if (sessions % 6 == 0) random_settings();
            random_session();
            sessions++;
        end

        drain_pipeline();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d requests (%0d acted on) over %0d sessions; %0d results checked.",
                 sent_count, live_requests, sessions, checked_count);
        $display("Runs: %0d started, %0d failed on recording start, %0d stopped; %0d writes.",
                 runs_started, starts_failed, runs_stopped, settings_written);
        if (fail_count == 0) begin
            $display("tb_capture_window_sequencer OK");
        end else begin
            $display("tb_capture_window_sequencer NOT OK");
        end
        $finish;
    end

endmodule

FILE: capture_window_sequencer.f
rtl/cws_pkg.sv
rtl/cws_cfg.sv
rtl/cws_core.sv
rtl/capture_window_sequencer.sv
rtl/cws_checker.sv
verif/tb_capture_window_sequencer.sv
